FILE: src/i2cm_pkg.sv
package i2cm_pkg;

  // Reset values of the two configuration registers.
  localparam logic [15:0] UNIT_TICKS_RST  = 16'd100;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

  // Default width of the delay-unit tick counter.
  localparam int unsigned UNIT_COUNT_WIDTH_DEF = 16;

  // Configuration register indexes.
  localparam logic REG_UNIT_TICKS  = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  // Command codes as they arrive on the bus.
  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_WRITE    = 3'd3,
    CMD_WAIT_ACK = 3'd4,
    CMD_READ     = 3'd5
  } cmd_e;

  // One tick word after classification, as it sits in the queue.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_level;
  } item_t;

  // Bus phases of the engine.
  typedef enum logic [14:0] {
    PH_IDLE    = 15'h0001,
    PH_S_HIGH  = 15'h0002,
    PH_S_LOW   = 15'h0004,
    PH_P_LOW   = 15'h0008,
    PH_P_HIGH  = 15'h0010,
    PH_K_REL   = 15'h0020,
    PH_K_HIGH  = 15'h0040,
    PH_K_POLL  = 15'h0080,
    PH_W_SETUP = 15'h0100,
    PH_W_HIGH  = 15'h0200,
    PH_W_LOW   = 15'h0400,
    PH_R_LOW   = 15'h0800,
    PH_R_HIGH  = 15'h1000,
    PH_A_LOW   = 15'h2000,
    PH_A_HIGH  = 15'h4000
  } phase_e;

  // Queue status handed from the front to the back.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

FILE: src/i2c_master_bit_engine.sv
// Channel   | Direction | Payload (lowest bit first)
// s_axis    | in        | tuser: command[2:0]; tdata: write_data[7:0], send_ack[8],
//           |           |        sda_level[9], zeros[15:10]
// m_axis    | out       | tdata: scl_level[0], sda_drive[1], sda_output_enable[2],
//           |           |        busy_res[3], done_res[4], read_data[12:5],
//           |           |        ack_error[13], zeros[15:14]
// cfg       | in        | cfg_we_i, cfg_idx_i (0 unit_ticks, 1 ack_timeout), cfg_data_i
//
// One word in gives one word out. It takes one word per cycle while the queue has room;
// each word passes through the two-entry input queue and then the output register.
// The engine advances one bus tick per word, so its single state update sets the rate.
// Reset (rst_ni low, asynchronous) releases the bus (SCL, SDA high, SDA driven),
// empties the queue and restores unit_ticks 100 and ack_timeout 250.
// A stalled output holds its word while the queue keeps taking up to two words.
module i2c_master_bit_engine
  import i2cm_pkg::*;
#(
  parameter int unsigned UNIT_COUNT_WIDTH = UNIT_COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Tick words in.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // write_data, send_ack, sda_level
  input  logic [2:0]  s_axis_tuser,  // command
  // Bus levels and status out.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // scl, sda, oe, busy, done, read_data, ack_error
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] unit_ticks_q;
  logic [7:0]  ack_timeout_q;
  queue_head_t head;
  logic        pop;

  // Configuration registers; the user must write them only while the engine is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ticks_q  <= UNIT_TICKS_RST;
      ack_timeout_q <= ACK_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_UNIT_TICKS:  unit_ticks_q  <= cfg_data_i;
        REG_ACK_TIMEOUT: ack_timeout_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Front: classifies the command and queues the word.
  i2cm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .head_o        (head),
    .pop_i         (pop)
  );

  // Back: runs the bus phases one tick per word and registers the result.
  i2cm_core #(
    .UNIT_COUNT_WIDTH (UNIT_COUNT_WIDTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .unit_ticks_i  (unit_ticks_q),
    .ack_timeout_i (ack_timeout_q),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: src/i2cm_front.sv
module i2cm_front
  import i2cm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  output queue_head_t head_o,
  input  logic        pop_i
);

  item_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push;
  item_t       item_in;
  cmd_e        cmd_cls;

  // Codes without meaning are folded into "no command".
  always_comb begin
    unique case (s_axis_tuser)
      CMD_START:    cmd_cls = CMD_START;
      CMD_STOP:     cmd_cls = CMD_STOP;
      CMD_WRITE:    cmd_cls = CMD_WRITE;
      CMD_WAIT_ACK: cmd_cls = CMD_WAIT_ACK;
      CMD_READ:     cmd_cls = CMD_READ;
      default:      cmd_cls = CMD_NONE;
    endcase
  end

  assign item_in.cmd        = cmd_cls;
  assign item_in.write_data = s_axis_tdata[7:0];
  assign item_in.send_ack   = s_axis_tdata[8];
  assign item_in.sda_level  = s_axis_tdata[9];

  assign s_axis_tready = (count_q != 2'd2);
  assign push          = s_axis_tvalid & s_axis_tready;

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != 2'd0)
    else $error("pop from empty queue");

endmodule

FILE: src/i2cm_core.sv
module i2cm_core
  import i2cm_pkg::*;
#(
  parameter int unsigned UNIT_COUNT_WIDTH = UNIT_COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] unit_ticks_i,
  input  logic [7:0]  ack_timeout_i,
  input  queue_head_t head_i,
  output logic        pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata
);

  localparam int unsigned UCW = UNIT_COUNT_WIDTH;

  phase_e           phase_q, phase_d;
  logic [UCW-1:0]   cnt_q, cnt_d;
  logic [2:0]       ul_q, ul_d;
  logic [2:0]       bit_q, bit_d;
  logic [7:0]       shift_q, shift_d;
  logic [7:0]       tmo_q, tmo_d;
  logic             ackc_q, ackc_d;
  logic             err_q, err_d;
  logic             scl_q, scl_d;
  logic             sda_q, sda_d;
  logic             oe_q, oe_d;
  logic [7:0]       rbyte_q, rbyte_d;
  logic             done;

  logic [UCW-1:0]   tpu_raw, tpu, cnt_inc;
  logic             unit_end;
  logic [2:0]       ul_dec;
  logic             out_valid_q;
  logic [15:0]      out_q;
  item_t            it;

  assign it      = head_i.item;
  assign pop_o   = head_i.valid & (~out_valid_q | m_axis_tready);

  assign tpu_raw  = UCW'(unit_ticks_i);
  assign tpu      = (tpu_raw == '0) ? UCW'(1) : tpu_raw;
  assign cnt_inc  = cnt_q + UCW'(1);
  assign unit_end = (cnt_inc >= tpu);
  assign ul_dec   = (ul_q != 3'd0) ? ul_q - 3'd1 : 3'd0;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    ul_d    = ul_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    tmo_d   = tmo_q;
    ackc_d  = ackc_q;
    err_d   = err_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    oe_d    = oe_q;
    rbyte_d = rbyte_q;
    done    = 1'b0;
    if (pop_o) begin
      unique case (phase_q)
        PH_IDLE: begin
          unique case (it.cmd)
            CMD_START: begin
              oe_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1;
              phase_d = PH_S_HIGH; ul_d = 3'd4; cnt_d = '0;
            end
            CMD_STOP: begin
              oe_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
              phase_d = PH_P_LOW; ul_d = 3'd4; cnt_d = '0;
            end
            CMD_WRITE: begin
              oe_d = 1'b1; scl_d = 1'b0;
              shift_d = it.write_data;
              bit_d = 3'd0;
              sda_d = it.write_data[7];
              phase_d = PH_W_SETUP; ul_d = 3'd2; cnt_d = '0;
            end
            CMD_WAIT_ACK: begin
              err_d = 1'b0;
              oe_d = 1'b0; sda_d = 1'b1;
              phase_d = PH_K_REL; ul_d = 3'd1; cnt_d = '0;
            end
            CMD_READ: begin
              ackc_d = it.send_ack;
              oe_d = 1'b0; scl_d = 1'b0;
              shift_d = 8'd0;
              bit_d = 3'd0;
              phase_d = PH_R_LOW; ul_d = 3'd2; cnt_d = '0;
            end
            default: ;
          endcase
        end
        PH_K_POLL: begin
          if (!it.sda_level) begin
            scl_d = 1'b0;
            err_d = 1'b0;
            done  = 1'b1;
          end else if (tmo_q == ack_timeout_i) begin
            // Slave never answered: error, then a stop condition.
            err_d = 1'b1;
            oe_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
            phase_d = PH_P_LOW; ul_d = 3'd4; cnt_d = '0;
          end else begin
            tmo_d = tmo_q + 8'd1;
          end
        end
        default: begin
          cnt_d = unit_end ? '0 : cnt_inc;
          if (unit_end) begin
            ul_d = ul_dec;
            if (ul_dec == 3'd0) begin
              unique case (phase_q)
                PH_S_HIGH: begin
                  sda_d = 1'b0; phase_d = PH_S_LOW; ul_d = 3'd4;
                end
                PH_S_LOW: begin
                  scl_d = 1'b0; done = 1'b1;
                end
                PH_P_LOW: begin
                  scl_d = 1'b1; sda_d = 1'b1; phase_d = PH_P_HIGH; ul_d = 3'd4;
                end
                PH_P_HIGH: done = 1'b1;
                PH_K_REL: begin
                  scl_d = 1'b1; phase_d = PH_K_HIGH; ul_d = 3'd1;
                end
                PH_K_HIGH: begin
                  tmo_d = 8'd0; phase_d = PH_K_POLL;
                end
                PH_W_SETUP: begin
                  scl_d = 1'b1; phase_d = PH_W_HIGH; ul_d = 3'd2;
                end
                PH_W_HIGH: begin
                  scl_d = 1'b0; phase_d = PH_W_LOW; ul_d = 3'd2;
                end
                PH_W_LOW: begin
                  if (bit_q == 3'd7) begin
                    done = 1'b1;
                  end else begin
                    bit_d   = bit_q + 3'd1;
                    shift_d = {shift_q[6:0], 1'b0};
                    sda_d   = shift_q[6];
                    phase_d = PH_W_SETUP; ul_d = 3'd2;
                  end
                end
                PH_R_LOW: begin
                  scl_d   = 1'b1;
                  shift_d = {shift_q[6:0], it.sda_level};
                  phase_d = PH_R_HIGH; ul_d = 3'd1;
                end
                PH_R_HIGH: begin
                  scl_d = 1'b0;
                  if (bit_q == 3'd7) begin
                    oe_d = 1'b1;
                    sda_d = ~ackc_q;
                    phase_d = PH_A_LOW; ul_d = 3'd2;
                  end else begin
                    bit_d = bit_q + 3'd1;
                    phase_d = PH_R_LOW; ul_d = 3'd2;
                  end
                end
                PH_A_LOW: begin
                  scl_d = 1'b1; phase_d = PH_A_HIGH; ul_d = 3'd2;
                end
                PH_A_HIGH: begin
                  scl_d = 1'b0; rbyte_d = shift_q; done = 1'b1;
                end
                default: done = 1'b1;
              endcase
            end
          end
        end
      endcase
      if (done) begin
        phase_d = PH_IDLE;
        ul_d    = 3'd0;
        cnt_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      ul_q        <= 3'd0;
      bit_q       <= 3'd0;
      shift_q     <= 8'd0;
      tmo_q       <= 8'd0;
      ackc_q      <= 1'b0;
      err_q       <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      oe_q        <= 1'b1;
      rbyte_q     <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      ul_q    <= ul_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      tmo_q   <= tmo_d;
      ackc_q  <= ackc_d;
      err_q   <= err_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      oe_q    <= oe_d;
      rbyte_q <= rbyte_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= {2'b00, err_d, rbyte_d, done, (phase_d != PH_IDLE),
                oe_d, sda_d, scl_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q[4] |-> !out_q[3])
    else $error("done reported while busy");

  a_timeout_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && phase_q == PH_K_POLL && it.sda_level && tmo_q == ack_timeout_i
    |=> phase_q == PH_P_LOW && err_q)
    else $error("ack timeout did not start a stop");

endmodule
